### hdl/sdpf_pkg.sv
// Shared types, constants and coil phase tables for the stepper dial follower.
package sdpf_pkg;

  localparam int DATA_W = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int TARGET_W = 12;
  localparam int PHASE_W = 3;
  localparam int COIL_W = 4;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [COIL_W-1:0] coil_t;

  localparam cfg_index_t REG_MAX_DELAY = 4'd0;
  localparam cfg_index_t REG_MIN_DELAY = 4'd1;
  localparam cfg_index_t REG_DECEL_GAIN = 4'd2;
  localparam cfg_index_t REG_ACCEL_DECREMENT = 4'd3;

  localparam word_t SPEED_PER_STEP = 16'd22;
  localparam logic signed [DATA_W:0] ACCEL_MARGIN = 17'sd10;

  localparam word_t MAX_DELAY_RESET = 16'd70;
  localparam word_t MIN_DELAY_RESET = 16'd5;
  localparam word_t DECEL_GAIN_RESET = 16'd1000;
  localparam word_t ACCEL_DECREMENT_RESET = 16'd2;
  localparam word_t PREV_DELAY_RESET = 16'd70;
  localparam phase_t PHASE_RESET = 3'd1;

  // Coil drive bits for each phase; phases outside one to six drive nothing.
  function automatic coil_t phase_coils(input phase_t phase);
    coil_t c;
    case (phase)
      3'd1: c = 4'd9;
      3'd2: c = 4'd8;
      3'd3: c = 4'd2;
      3'd4: c = 4'd6;
      3'd5: c = 4'd4;
      3'd6: c = 4'd1;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic phase_t phase_cw(input phase_t phase);
    phase_t p;
    case (phase)
      3'd1: p = 3'd6;
      3'd2: p = 3'd1;
      3'd3: p = 3'd2;
      3'd4: p = 3'd3;
      3'd5: p = 3'd4;
      3'd6: p = 3'd5;
      default: p = phase;
    endcase
    return p;
  endfunction

  function automatic phase_t phase_ccw(input phase_t phase);
    phase_t p;
    case (phase)
      3'd1: p = 3'd2;
      3'd2: p = 3'd3;
      3'd3: p = 3'd4;
      3'd4: p = 3'd5;
      3'd5: p = 3'd6;
      3'd6: p = 3'd1;
      default: p = phase;
    endcase
    return p;
  endfunction

endpackage

### hdl/stepper_dial_position_follower.sv
// Top level of the stepper dial follower: sequencer, bit-serial divider and state.
//
// One input beat on in_valid/in_ready carries engine_speed for one step-timer
// tick; one output beat on out_valid/out_ready returns the step delay, the
// step flags, the coil pattern and the remaining error for that tick.
// Registers are written over cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and indexes beyond three are dropped.
//
// A tick runs S_DIV_TGT, S_ERR, S_DIV_GAIN, S_DELAY and S_DONE when the dial is
// off target; on target S_ERR goes straight to S_DONE. Both divisions use the
// one shared restoring divider, which retires one quotient bit per cycle:
// first speed / 22, then decel_gain / |error|.
// in_ready is high only while no tick is being worked on, so one tick runs
// at a time: a new tick is not taken before the last one leaves S_DONE.
// A new tick may enter while the previous result still waits.
// If the receiver stalls, the finished tick holds in its last step until
// the output register frees, and state is updated only when the result
// is loaded there.
// Reset (rst, synchronous) restores the register defaults, clears the
// error and target, sets the stored delay to 70 and the coil phase to one.
module stepper_dial_position_follower (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sdpf_pkg::word_t        engine_speed,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sdpf_pkg::word_t        step_delay,
  output logic                   step_taken,
  output logic                   step_clockwise,
  output sdpf_pkg::coil_t        coil_pattern,
  output logic signed [15:0]     error_left,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  sdpf_pkg::cfg_index_t   cfg_index,
  input  sdpf_pkg::word_t        cfg_data
);
  import sdpf_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_TGT  = 3'd1;
  localparam logic [2:0] S_ERR      = 3'd2;
  localparam logic [2:0] S_DIV_GAIN = 3'd3;
  localparam logic [2:0] S_DELAY    = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state;

  word_t max_delay, min_delay, decel_gain, accel_decrement;

  logic [TARGET_W-1:0] prev_target;
  logic signed [DATA_W-1:0] step_error;
  word_t prev_delay;
  phase_t coil_phase;

  // Divider registers.
  word_t div_rem, div_quo, div_dvs;
  logic [3:0] div_cnt;

  logic [TARGET_W-1:0] target;
  logic signed [DATA_W-1:0] err_sat;
  word_t delay;

  // One restoring division step.
  logic [DATA_W:0] div_shift, div_trial;
  always_comb begin
    div_shift = {div_rem, div_quo[DATA_W-1]};
    div_trial = div_shift - {1'b0, div_dvs};
  end

  // Error after the target change, saturated to the signed 16-bit range.
  logic signed [DATA_W+1:0] err_sum;
  logic signed [DATA_W-1:0] err_new;
  word_t err_abs;
  always_comb begin
    err_sum = {{2{step_error[DATA_W-1]}}, step_error}
            + $signed({6'd0, div_quo[TARGET_W-1:0]})
            - $signed({6'd0, prev_target});
    if (err_sum > 18'sd32767) begin
      err_new = 16'sh7fff;
    end else if (err_sum < -18'sd32768) begin
      err_new = 16'sh8000;
    end else begin
      err_new = err_sum[DATA_W-1:0];
    end
    // The magnitude of the most negative error still fits 16 unsigned bits.
    err_abs = err_new[DATA_W-1] ? (16'd0 - err_new) : err_new;
  end

  // Clamped delay from the gain quotient.
  logic [DATA_W:0] delay_sum;
  word_t delay_clamped;
  always_comb begin
    delay_sum = {1'b0, div_quo} + {1'b0, min_delay};
    delay_clamped = (delay_sum > {1'b0, max_delay}) ? max_delay : delay_sum[DATA_W-1:0];
  end

  // Result and state updates for the finished tick.
  logic load_out;
  logic signed [DATA_W:0] delay_drop;
  word_t issued, prev_delay_next;
  logic err_pos, err_neg;
  phase_t phase_next;
  logic signed [DATA_W-1:0] step_error_next;
  always_comb begin
    load_out = (state == S_DONE) && (!out_valid || out_ready);
    delay_drop = $signed({1'b0, prev_delay}) - $signed({1'b0, delay});
    if (delay_drop > ACCEL_MARGIN) begin
      issued = prev_delay;
      prev_delay_next = (prev_delay > accel_decrement) ? prev_delay - accel_decrement
                                                       : '0;
    end else begin
      issued = delay;
      prev_delay_next = delay;
    end
    err_pos = !err_sat[DATA_W-1] && (err_sat != '0);
    err_neg = err_sat[DATA_W-1];
    if (err_pos) begin
      phase_next = phase_cw(coil_phase);
      step_error_next = err_sat - 16'sd1;
    end else if (err_neg) begin
      phase_next = phase_ccw(coil_phase);
      step_error_next = err_sat + 16'sd1;
    end else begin
      phase_next = coil_phase;
      step_error_next = err_sat;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay <= MAX_DELAY_RESET;
      min_delay <= MIN_DELAY_RESET;
      decel_gain <= DECEL_GAIN_RESET;
      accel_decrement <= ACCEL_DECREMENT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_DELAY:       max_delay <= cfg_data;
        REG_MIN_DELAY:       min_delay <= cfg_data;
        REG_DECEL_GAIN:      decel_gain <= cfg_data;
        REG_ACCEL_DECREMENT: accel_decrement <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      prev_target <= '0;
      step_error <= '0;
      prev_delay <= PREV_DELAY_RESET;
      coil_phase <= PHASE_RESET;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            div_quo <= engine_speed;
            div_rem <= '0;
            div_dvs <= SPEED_PER_STEP;
            div_cnt <= '0;
            state <= S_DIV_TGT;
          end
        end
        S_DIV_TGT, S_DIV_GAIN: begin
          if (!div_trial[DATA_W]) begin
            div_rem <= div_trial[DATA_W-1:0];
            div_quo <= {div_quo[DATA_W-2:0], 1'b1};
          end else begin
            div_rem <= div_shift[DATA_W-1:0];
            div_quo <= {div_quo[DATA_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) begin
            state <= (state == S_DIV_TGT) ? S_ERR : S_DELAY;
          end
        end
        S_ERR: begin
          target <= div_quo[TARGET_W-1:0];
          err_sat <= err_new;
          if (err_new == '0) begin
            delay <= max_delay;
            state <= S_DONE;
          end else begin
            div_quo <= decel_gain;
            div_rem <= '0;
            div_dvs <= err_abs;
            div_cnt <= '0;
            state <= S_DIV_GAIN;
          end
        end
        S_DELAY: begin
          delay <= delay_clamped;
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            step_delay <= issued;
            step_taken <= err_pos || err_neg;
            step_clockwise <= err_pos;
            coil_pattern <= phase_coils(phase_next);
            error_left <= step_error_next;
            prev_target <= target;
            step_error <= step_error_next;
            prev_delay <= prev_delay_next;
            coil_phase <= phase_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/sdpf_checker.sv
// Port-level checks for the stepper dial follower, bound to its top level.
module sdpf_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input sdpf_pkg::word_t      step_delay,
  input logic                 step_taken,
  input logic                 step_clockwise,
  input sdpf_pkg::coil_t      coil_pattern,
  input logic signed [15:0]   error_left
);
  import sdpf_pkg::*;

  // Only one tick is worked on at a time.
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a tick is in progress");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(step_delay) && $stable(error_left))
    else $error("stalled result changed");

  a_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && !step_taken |-> !step_clockwise)
    else $error("direction set without a step");

  // A step moves the error one nearer zero, so it cannot cross zero.
  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_taken |->
      (step_clockwise ? !error_left[15] : (error_left[15] || error_left == 16'sd0)))
    else $error("error left has the wrong sign for the step direction");

  a_coil: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> coil_pattern != 4'd0)
    else $error("coil pattern of an invalid phase");

endmodule

bind stepper_dial_position_follower sdpf_checker u_sdpf_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .step_delay(step_delay),
  .step_taken(step_taken),
  .step_clockwise(step_clockwise),
  .coil_pattern(coil_pattern),
  .error_left(error_left)
);

### bench/testbench.sv
// Self-checking testbench for the stepper dial position follower.
module testbench;
  import sdpf_pkg::*;

  localparam int RPM_PER_STEP = 22;
  localparam int ACCEL_SLACK = 10;
  localparam int TICK_LATENCY = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int BACKPRESSURE_CYCLES = 2000;
  localparam int DIRECTED_ROWS = 24;
  localparam cfg_index_t REG_UNUSED = 4'd15;

  // Tables indexed by phase, phase seven in the top slice and phase zero in the bottom one.
  localparam logic [31:0] COIL_BY_PHASE = {4'd0, 4'd1, 4'd4, 4'd6, 4'd2, 4'd8, 4'd9, 4'd0};
  localparam logic [23:0] PHASE_AFTER_CW =
    {3'd7, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd6, 3'd0};
  localparam logic [23:0] PHASE_AFTER_CCW =
    {3'd7, 3'd1, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0};

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    word_t              delay;
    logic               taken;
    logic               clockwise;
    coil_t              coils;
    logic signed [15:0] err;
  } tick_result_t;

  typedef struct packed {
    word_t        speed;
    logic         typed;
    tick_result_t want;
  } speed_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  word_t              engine_speed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  word_t              step_delay;
  logic               step_taken;
  logic               step_clockwise;
  coil_t              coil_pattern;
  logic signed [15:0] error_left;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_index_t         cfg_index = REG_MAX_DELAY;
  word_t              cfg_data = '0;

  stepper_dial_position_follower u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .engine_speed   (engine_speed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .step_delay     (step_delay),
    .step_taken     (step_taken),
    .step_clockwise (step_clockwise),
    .coil_pattern   (coil_pattern),
    .error_left     (error_left),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // Our own copy of the follower state and its registers.
  int     cfg_max = 70;
  int     cfg_min = 5;
  int     cfg_gain = 1000;
  int     cfg_decr = 2;
  int     dial_target = 0;
  int     dial_error = 0;
  int     held_delay = 70;
  phase_t coil_phase_q = 3'd1;

  tick_result_t expected_ticks[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int settings = 1;

  function automatic tick_result_t follow_tick(input word_t speed);
    int target;
    int err;
    int mag;
    int delay;
    tick_result_t r;
    target = (int'(speed) / RPM_PER_STEP) & 'hFFF;
    err = dial_error + target - dial_target;
    if (err > 32767) err = 32767;
    if (err < -32768) err = -32768;
    dial_target = target;

    if (err == 0) begin
      delay = cfg_max;
    end else begin
      mag = (err < 0) ? -err : err;
      delay = cfg_gain / mag + cfg_min;
      if (delay > cfg_max) delay = cfg_max;
    end

    // While accelerating, the stored delay steps down instead of jumping.
    if (held_delay - delay > ACCEL_SLACK) begin
      r.delay = word_t'(held_delay);
      held_delay = (held_delay > cfg_decr) ? held_delay - cfg_decr : 0;
    end else begin
      r.delay = word_t'(delay);
      held_delay = delay;
    end

    r.taken = (err != 0);
    r.clockwise = (err > 0);
    if (err > 0) begin
      coil_phase_q = PHASE_AFTER_CW[coil_phase_q*3 +: 3];
      err = err - 1;
    end else if (err < 0) begin
      coil_phase_q = PHASE_AFTER_CCW[coil_phase_q*3 +: 3];
      err = err + 1;
    end
    dial_error = err;
    r.coils = COIL_BY_PHASE[coil_phase_q*4 +: 4];
    r.err = err[15:0];
    return r;
  endfunction

  task automatic send_speed(input word_t speed, input logic typed, input tick_result_t want);
    int gap;
    tick_result_t predicted;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    engine_speed <= speed;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predicted = follow_tick(speed);
    expected_ticks.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      REG_MAX_DELAY:       cfg_max = value;
      REG_MIN_DELAY:       cfg_min = value;
      REG_DECEL_GAIN:      cfg_gain = value;
      REG_ACCEL_DECREMENT: cfg_decr = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic run_phase(input idle_mode_t mode, input word_t max_d, input word_t min_d,
                           input word_t gain, input word_t decr, input int count,
                           input bit poke_unused, input bit squeeze);
    int last;
    int s;
    int r;
    int k;
    // Registers change only with no tick in flight.
    while (expected_ticks.size() != 0) @(posedge clk);
    write_reg(REG_MAX_DELAY, max_d);
    write_reg(REG_MIN_DELAY, min_d);
    write_reg(REG_DECEL_GAIN, gain);
    write_reg(REG_ACCEL_DECREMENT, decr);
    if (poke_unused) write_reg(REG_UNUSED, word_t'($urandom));
    cfg_valid <= 1'b0;
    settings++;

    tx_idle_pct = (mode == IDLE_SENDER) ? 53 : (mode == IDLE_BOTH) ? 8 : 0;
    rx_stall_pct = (mode == IDLE_RECEIVER) ? 53 : (mode == IDLE_BOTH) ? 8 : 0;
    if (squeeze) hold_request = 1'b1;

    // Mostly a slowly moving engine speed with holds, so the dial settles and
    // the accelerate and decelerate paths both get exercised.
    last = $urandom_range(65535);
    for (k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        s = last + int'($urandom_range(600)) - 300;
        if (s < 0) s = 0;
        if (s > 65535) s = 65535;
      end else if (r < 70) begin
        s = last;
      end else if (r < 80) begin
        s = ($urandom_range(1) != 0) ? 65535 : 0;
      end else begin
        s = $urandom_range(65535);
      end
      send_speed(word_t'(s), 1'b0, '0);
      last = s;
    end
    in_valid <= 1'b0;
  endtask

  // Output side: random stalls, plus one long hold-off that fills the block.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = BACKPRESSURE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Both sides are stable at the falling edge, so a beat seen here is taken
  // at the next rising edge.
  always @(negedge clk) begin : result_check
    tick_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_ticks.size() == 0) begin
        $error("result beat with no tick outstanding: step_delay %0d", step_delay);
        mismatches++;
      end else begin
        want = expected_ticks.pop_front();
        if (step_delay !== want.delay) begin
          $error("step_delay: expected %0d, got %0d", want.delay, step_delay);
          mismatches++;
        end
        if (step_taken !== want.taken) begin
          $error("step_taken: expected %0d, got %0d", want.taken, step_taken);
          mismatches++;
        end
        if (step_clockwise !== want.clockwise) begin
          $error("step_clockwise: expected %0d, got %0d", want.clockwise, step_clockwise);
          mismatches++;
        end
        if (coil_pattern !== want.coils) begin
          $error("coil_pattern: expected %0d, got %0d", want.coils, coil_pattern);
          mismatches++;
        end
        if (error_left !== want.err) begin
          $error("error_left: expected %0d, got %0d", want.err, error_left);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("** stepper_dial_position_follower: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    speed_row_t rows [DIRECTED_ROWS];
    int i;
    // Reset defaults give the first three results by hand: on target, then a
    // full-scale jump that steps clockwise while the delay ramps down.
    rows = '{
      {16'd0,     1'b1, 16'd70, 1'b0, 1'b0, 4'd9, 16'd0},
      {16'd65535, 1'b1, 16'd70, 1'b1, 1'b1, 4'd1, 16'd2977},
      {16'd65535, 1'b1, 16'd68, 1'b1, 1'b1, 4'd4, 16'd2976},
      {16'd0,     1'b0, 38'd0},
      {16'd0,     1'b0, 38'd0},
      {16'd21,    1'b0, 38'd0},
      {16'd22,    1'b0, 38'd0},
      {16'd22,    1'b0, 38'd0},
      {16'd43,    1'b0, 38'd0},
      {16'd44,    1'b0, 38'd0},
      {16'd44,    1'b0, 38'd0},
      {16'd65534, 1'b0, 38'd0},
      {16'd32768, 1'b0, 38'd0},
      {16'd1,     1'b0, 38'd0},
      {16'd2200,  1'b0, 38'd0},
      {16'd2210,  1'b0, 38'd0},
      {16'd21845, 1'b0, 38'd0},
      {16'd43690, 1'b0, 38'd0},
      {16'd65535, 1'b0, 38'd0},
      {16'd0,     1'b0, 38'd0},
      {16'd22,    1'b0, 38'd0},
      {16'd22,    1'b0, 38'd0},
      {16'd0,     1'b0, 38'd0},
      {16'd0,     1'b0, 38'd0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_speed(rows[i].speed, rows[i].typed, rows[i].want);
    end
    in_valid <= 1'b0;

    run_phase(IDLE_NONE, 16'd65535, 16'd0, 16'd65535, 16'd1, 150, 1'b0, 1'b0);
    // All zero: the decrement of zero pins the stored delay where it is.
    run_phase(IDLE_SENDER, 16'd0, 16'd0, 16'd0, 16'd0, 100, 1'b0, 1'b0);
    // Minimum above maximum, and a decrement that drives the stored delay to zero.
    run_phase(IDLE_RECEIVER, 16'd100, 16'd200, 16'd500, 16'd65535, 150, 1'b1, 1'b0);
    run_phase(IDLE_BOTH, 16'd300, 16'd3, 16'd20000, 16'd7, 150, 1'b0, 1'b0);
    run_phase(IDLE_SENDER, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 100, 1'b0, 1'b0);
    run_phase(IDLE_RECEIVER, 16'd70, 16'd5, 16'd1000, 16'd2, 150, 1'b0, 1'b1);
    run_phase(IDLE_NONE, word_t'($urandom_range(65535)), word_t'($urandom_range(300)),
              word_t'($urandom_range(65535)), word_t'($urandom_range(20)), 150, 1'b0, 1'b0);
    run_phase(IDLE_BOTH, word_t'($urandom), word_t'($urandom), word_t'($urandom),
              word_t'($urandom), 150, 1'b1, 1'b0);

    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (TICK_LATENCY) @(posedge clk);

    $display("Sent %0d ticks (%0d directed) under %0d register settings, %0d writes; %0d checked.",
             ticks_sent, DIRECTED_ROWS, settings, reg_writes, results_seen);
    $display("Traffic ran unthrottled, with sender gaps, receiver stalls, both, and a %0d-cycle hold.",
             BACKPRESSURE_CYCLES);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("** stepper_dial_position_follower: PASSED **");
    end else begin
      if (expected_ticks.size() != 0) begin
        $error("%0d expected results never arrived", expected_ticks.size());
      end
      $display("** stepper_dial_position_follower: FAILED **");
    end
    $finish;
  end

endmodule

### stepper_dial_position_follower.f
hdl/sdpf_pkg.sv
hdl/stepper_dial_position_follower.sv
hdl/sdpf_checker.sv
bench/testbench.sv
